>>> hdl/note_event_to_midi_key_tracker_macros.svh
// assertion macros shared by the note key tracker modules
`ifndef NOTE_EVENT_TO_MIDI_KEY_TRACKER_MACROS_SVH
`define NOTE_EVENT_TO_MIDI_KEY_TRACKER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define NMKT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define NMKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/nmkt_pkg.sv
// shared constants, types and key threshold table of the note key tracker
`default_nettype none

package nmkt_pkg;

  localparam int NumKeys      = 128;
  localparam int KeyWidth     = $clog2(NumKeys);
  localparam int IdWidth      = 32;
  localparam int NoteIdWidth  = 32;
  localparam int FreqWidth    = 32;
  localparam int TimeWidth    = 32;
  localparam int VelInWidth   = 16;
  localparam int MidiVelWidth = 7;
  localparam int CfgWidth     = 8;
  localparam int FracBits     = 12;
  localparam int ProdWidth    = VelInWidth + CfgWidth + 1;
  localparam int QueueDepth   = 2;
  localparam int BitCntWidth  = $clog2(KeyWidth);

  localparam logic [CfgWidth-1:0]     BaseVelReset = CfgWidth'(127);
  localparam logic [MidiVelWidth-1:0] MidiVelMax   = MidiVelWidth'(127);

  localparam real RefFreqQ12 = 440.0 * 4096.0;
  localparam real RefKey     = 69.0;
  localparam real SemisPerOct = 12.0;

  // one boundary per key step, integer part of the Q20.12 boundary frequency
  typedef logic [NumKeys-2:0][FreqWidth-1:0] thresh_t;

  function automatic thresh_t build_thresholds();
    thresh_t t;
    real     r;
    for (int k = 0; k < NumKeys - 1; k++) begin
      // boundary halfway (in pitch) between key k and key k+1
      r    = RefFreqQ12 * (2.0 ** ((real'(k) + 0.5 - RefKey) / SemisPerOct));
      t[k] = FreqWidth'($rtoi(r));
    end
    return t;
  endfunction

  localparam thresh_t KeyThresh = build_thresholds();

  // command passed from the front end to the key table
  typedef struct packed {
    logic                    is_on;
    logic [KeyWidth-1:0]     key;
    logic [MidiVelWidth-1:0] vel;
    logic [IdWidth-1:0]      id;
    logic [TimeWidth-1:0]    ftime;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/nmkt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module nmkt_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/nmkt_front.sv
// front end: accepts note events, finds the key and scales the velocity
`default_nettype none

module nmkt_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 gate_i,
  input  wire logic signed [nmkt_pkg::NoteIdWidth-1:0] note_id_i,
  input  wire logic                                 has_frequency_i,
  input  wire logic        [nmkt_pkg::FreqWidth-1:0]   frequency_i,
  input  wire logic signed [nmkt_pkg::VelInWidth-1:0]  velocity_i,
  input  wire logic        [nmkt_pkg::TimeWidth-1:0]   frame_time_i,
  input  wire logic        [nmkt_pkg::CfgWidth-1:0]    base_velocity_i,
  input  wire logic                                 full_i,
  output logic                                      push_o,
  output nmkt_pkg::cmd_t                            cmd_o
);

  localparam int QuotWidth = nmkt_pkg::ProdWidth - 1 - nmkt_pkg::FracBits;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SRCH = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic [nmkt_pkg::KeyWidth-1:0]    key_q, key_d;
  logic [nmkt_pkg::BitCntWidth-1:0] bit_q, bit_d;

  logic                                       gate_q;
  logic        [nmkt_pkg::IdWidth-1:0]        id_q;
  logic        [nmkt_pkg::FreqWidth-1:0]      freq_q;
  logic signed [nmkt_pkg::VelInWidth-1:0]     vel_q;
  logic        [nmkt_pkg::TimeWidth-1:0]      time_q;
  logic signed [nmkt_pkg::ProdWidth-1:0]      prod_q, prod_d;

  logic                              accept;
  logic [nmkt_pkg::KeyWidth-1:0]     cand;
  logic [nmkt_pkg::KeyWidth-1:0]     cand_idx;
  logic                              step_hit;
  logic [nmkt_pkg::MidiVelWidth-1:0] vel_clamped;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // binary search: key is the number of boundaries the frequency lies above
  assign cand     = key_q | (nmkt_pkg::KeyWidth'(1) << bit_q);
  assign cand_idx = cand - nmkt_pkg::KeyWidth'(1);
  assign step_hit = freq_q > nmkt_pkg::KeyThresh[cand_idx];

  always_comb begin
    if (prod_q <= 0) begin
      vel_clamped = '0;
    end else if (prod_q[nmkt_pkg::ProdWidth-2:nmkt_pkg::FracBits] >
                 QuotWidth'(nmkt_pkg::MidiVelMax)) begin
      vel_clamped = nmkt_pkg::MidiVelMax;
    end else begin
      vel_clamped = prod_q[nmkt_pkg::FracBits+nmkt_pkg::MidiVelWidth-1:nmkt_pkg::FracBits];
    end
  end

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    bit_d   = bit_q;
    prod_d  = prod_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        key_d = '0;
        bit_d = nmkt_pkg::BitCntWidth'(nmkt_pkg::KeyWidth - 1);
        if (accept) begin
          if (!gate_i) begin
            state_d = F_PUSH;
          end else if (has_frequency_i) begin
            state_d = F_SRCH;
          end
          // note-on without a frequency is dropped here
        end
      end
      F_SRCH: begin
        prod_d = vel_q * $signed({1'b0, base_velocity_i});
        if (step_hit) begin
          key_d = cand;
        end
        if (bit_q == '0) begin
          state_d = F_PUSH;
        end else begin
          bit_d = bit_q - nmkt_pkg::BitCntWidth'(1);
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.is_on = gate_q;
    cmd_o.key   = gate_q ? key_q : '0;
    cmd_o.vel   = gate_q ? vel_clamped : '0;
    cmd_o.id    = id_q;
    cmd_o.ftime = time_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    bit_q  <= bit_d;
    prod_q <= prod_d;
    if (accept) begin
      gate_q <= gate_i;
      id_q   <= note_id_i[nmkt_pkg::IdWidth-1:0];
      freq_q <= frequency_i;
      vel_q  <= velocity_i;
      time_q <= frame_time_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/nmkt_queue.sv
// short command queue between the front end and the key table
`default_nettype none
`include "note_event_to_midi_key_tracker_macros.svh"

module nmkt_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire nmkt_pkg::cmd_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output nmkt_pkg::cmd_t      data_o
);

  localparam int PtrWidth = $clog2(nmkt_pkg::QueueDepth);
  localparam int CntWidth = $clog2(nmkt_pkg::QueueDepth + 1);

  nmkt_pkg::cmd_t entry_q [nmkt_pkg::QueueDepth];

  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] count_q;

  assign full_o  = (count_q == CntWidth'(nmkt_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(nmkt_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(nmkt_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + PtrWidth'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntWidth'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `NMKT_ASSERT_IMPL(a_no_overflow, push_i, !full_o || pop_i, "push into a full queue")
  `NMKT_ASSERT_IMPL(a_no_underflow, pop_i, valid_o, "pop from an empty queue")
  `NMKT_ASSERT_IMPL(a_full_has_data, full_o, valid_o, "full queue reports no data")

endmodule

`default_nettype wire

>>> hdl/nmkt_back.sv
// back end: key ownership table, note-off scan and result register
`default_nettype none
`include "note_event_to_midi_key_tracker_macros.svh"

module nmkt_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_valid_i,
  input  wire nmkt_pkg::cmd_t                      q_cmd_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     is_note_on_o,
  output logic [nmkt_pkg::KeyWidth-1:0]            key_o,
  output logic [nmkt_pkg::MidiVelWidth-1:0]        midi_velocity_o,
  output logic [nmkt_pkg::TimeWidth-1:0]           event_time_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_EMIT = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  logic [nmkt_pkg::NumKeys-1:0]  busy_q, busy_d;
  logic [nmkt_pkg::KeyWidth-1:0] issue_q, issue_d;
  logic                          chk_vld_q, chk_vld_d;
  logic [nmkt_pkg::KeyWidth-1:0] chk_idx_q, chk_idx_d;
  logic [nmkt_pkg::KeyWidth-1:0] hit_key_q, hit_key_d;
  logic [nmkt_pkg::IdWidth-1:0]  id_q, id_d;
  logic [nmkt_pkg::TimeWidth-1:0] time_q, time_d;

  logic                              out_valid_q;
  logic                              out_on_q;
  logic [nmkt_pkg::KeyWidth-1:0]     out_key_q;
  logic [nmkt_pkg::MidiVelWidth-1:0] out_vel_q;
  logic [nmkt_pkg::TimeWidth-1:0]    out_time_q;

  logic                              out_free;
  logic                              out_load;
  logic                              ld_on;
  logic [nmkt_pkg::KeyWidth-1:0]     ld_key;
  logic [nmkt_pkg::MidiVelWidth-1:0] ld_vel;
  logic [nmkt_pkg::TimeWidth-1:0]    ld_time;

  logic                          ram_we;
  logic [nmkt_pkg::KeyWidth-1:0] ram_waddr;
  logic [nmkt_pkg::IdWidth-1:0]  ram_rdata;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign ram_waddr = q_cmd_i.key;

  nmkt_ram #(
    .Width (nmkt_pkg::IdWidth),
    .Depth (nmkt_pkg::NumKeys)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (q_cmd_i.id),
    .raddr_i (issue_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    issue_d   = issue_q;
    chk_vld_d = chk_vld_q;
    chk_idx_d = chk_idx_q;
    hit_key_d = hit_key_q;
    id_d      = id_q;
    time_d    = time_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    ld_on     = 1'b0;
    ld_key    = hit_key_q;
    ld_vel    = '0;
    ld_time   = time_q;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.is_on) begin
            if (out_free) begin
              pop_o = 1'b1;
              // note-on on a busy key is dropped
              if (!busy_q[q_cmd_i.key]) begin
                busy_d[q_cmd_i.key] = 1'b1;
                ram_we   = 1'b1;
                out_load = 1'b1;
                ld_on    = 1'b1;
                ld_key   = q_cmd_i.key;
                ld_vel   = q_cmd_i.vel;
                ld_time  = q_cmd_i.ftime;
              end
            end
          end else begin
            pop_o     = 1'b1;
            id_d      = q_cmd_i.id;
            time_d    = q_cmd_i.ftime;
            issue_d   = '0;
            chk_vld_d = 1'b0;
            state_d   = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        // read address runs one entry ahead of the compare
        issue_d   = issue_q + nmkt_pkg::KeyWidth'(1);
        chk_vld_d = 1'b1;
        chk_idx_d = issue_q;
        if (chk_vld_q) begin
          if (busy_q[chk_idx_q] && (ram_rdata == id_q)) begin
            busy_d[chk_idx_q] = 1'b0;
            hit_key_d = chk_idx_q;
            state_d   = B_EMIT;
          end else if (chk_idx_q == nmkt_pkg::KeyWidth'(nmkt_pkg::NumKeys - 1)) begin
            state_d = B_IDLE;
          end
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      busy_q      <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      busy_q    <= busy_d;
      chk_vld_q <= chk_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q   <= issue_d;
    chk_idx_q <= chk_idx_d;
    hit_key_q <= hit_key_d;
    id_q      <= id_d;
    time_q    <= time_d;
    if (out_load) begin
      out_on_q   <= ld_on;
      out_key_q  <= ld_key;
      out_vel_q  <= ld_vel;
      out_time_q <= ld_time;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_note_on_o    = out_on_q;
  assign key_o           = out_key_q;
  assign midi_velocity_o = out_vel_q;
  assign event_time_o    = out_time_q;

  `NMKT_ASSERT_NEXT(a_on_marks_key, ram_we, busy_q[$past(ram_waddr)], "written key not busy")
  `NMKT_ASSERT_IMPL(a_emit_key_free, state_q == B_EMIT, !busy_q[hit_key_q], "released key busy")
  `NMKT_ASSERT_IMPL(a_load_slot_free, out_load, out_free, "result overwrites pending result")

endmodule

`default_nettype wire

>>> hdl/note_event_to_midi_key_tracker.sv
// Note event to MIDI key tracker. A note-on with a frequency maps to the nearest
// key (binary search over a constant boundary table, 7 compare steps), scales its
// velocity by base_velocity and claims the key if free; a note-off scans the
// 128-entry owner ram from key 0 upward and frees the first key holding the id.
// The front end handles a note-on as accept, 7 search steps and push, and a note-off
// as accept and push, waiting longer while the queue is full; a two-entry command
// queue decouples it from the key table, where a note-off scan does one ram read
// per key with a pipelined compare. Busy bits reset to zero at once, so no clearing
// pass is needed. base_velocity resets to 127; the user must write it only while
// idle, the block itself does not enforce this.
`default_nettype none

module note_event_to_midi_key_tracker (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic        [nmkt_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic                                    gate_i,
  input  wire logic signed [nmkt_pkg::NoteIdWidth-1:0] note_id_i,
  input  wire logic                                    has_frequency_i,
  input  wire logic        [nmkt_pkg::FreqWidth-1:0]   frequency_i,
  input  wire logic signed [nmkt_pkg::VelInWidth-1:0]  velocity_i,
  input  wire logic        [nmkt_pkg::TimeWidth-1:0]   frame_time_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic                                         is_note_on_o,
  output logic             [nmkt_pkg::KeyWidth-1:0]    key_o,
  output logic             [nmkt_pkg::MidiVelWidth-1:0] midi_velocity_o,
  output logic             [nmkt_pkg::TimeWidth-1:0]   event_time_o
);

  logic [nmkt_pkg::CfgWidth-1:0] base_vel_q;

  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  nmkt_pkg::cmd_t push_cmd;
  nmkt_pkg::cmd_t head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vel_q <= nmkt_pkg::BaseVelReset;
    end else if (cfg_we_i) begin
      base_vel_q <= cfg_wdata_i;
    end
  end

  nmkt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .gate_i          (gate_i),
    .note_id_i       (note_id_i),
    .has_frequency_i (has_frequency_i),
    .frequency_i     (frequency_i),
    .velocity_i      (velocity_i),
    .frame_time_i    (frame_time_i),
    .base_velocity_i (base_vel_q),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  nmkt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (head_cmd)
  );

  nmkt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_note_on_o    (is_note_on_o),
    .key_o           (key_o),
    .midi_velocity_o (midi_velocity_o),
    .event_time_o    (event_time_o)
  );

endmodule

`default_nettype wire

>>> tb/note_event_to_midi_key_tracker_test.sv
// self-checking regression for the note event to midi key tracker
`timescale 1ns / 1ps

module note_event_to_midi_key_tracker_test;

  localparam int LimitCycles  = 2_000_000;
  localparam int SettleCycles = 400;
  localparam int HoldCycles   = 500;
  localparam int PhaseItems   = 275;
  localparam int NumPhases    = 6;
  localparam int IdlePct      = 28;
  localparam bit GateOn       = 1'b1;
  localparam bit GateOff      = 1'b0;
  localparam logic [nmkt_pkg::FreqWidth-1:0] A440Q12 = 32'd1802240;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_NOTE} row_check_e;

  typedef struct {
    logic                                    gate;
    logic signed [nmkt_pkg::NoteIdWidth-1:0] id;
    logic                                    has_freq;
    logic [nmkt_pkg::FreqWidth-1:0]          freq;
    logic signed [nmkt_pkg::VelInWidth-1:0]  vel;
    logic [nmkt_pkg::TimeWidth-1:0]          ftime;
  } note_event_t;

  typedef struct {
    logic                              is_on;
    logic [nmkt_pkg::KeyWidth-1:0]     key;
    logic [nmkt_pkg::MidiVelWidth-1:0] vel;
    logic [nmkt_pkg::TimeWidth-1:0]    etime;
  } midi_note_t;

  typedef struct {
    row_check_e  check;
    note_event_t ev;
    midi_note_t  res;
  } dir_row_t;

  logic                                    clk_i           = 1'b0;
  logic                                    rst_ni          = 1'b0;
  logic                                    cfg_we_i        = 1'b0;
  logic [nmkt_pkg::CfgWidth-1:0]           cfg_wdata_i     = '0;
  logic                                    in_valid_i      = 1'b0;
  logic                                    in_stall_o;
  logic                                    gate_i          = 1'b0;
  logic signed [nmkt_pkg::NoteIdWidth-1:0] note_id_i       = '0;
  logic                                    has_frequency_i = 1'b0;
  logic [nmkt_pkg::FreqWidth-1:0]          frequency_i     = '0;
  logic signed [nmkt_pkg::VelInWidth-1:0]  velocity_i      = '0;
  logic [nmkt_pkg::TimeWidth-1:0]          frame_time_i    = '0;
  logic                                    out_valid_o;
  logic                                    out_stall_i     = 1'b0;
  logic                                    is_note_on_o;
  logic [nmkt_pkg::KeyWidth-1:0]           key_o;
  logic [nmkt_pkg::MidiVelWidth-1:0]       midi_velocity_o;
  logic [nmkt_pkg::TimeWidth-1:0]          event_time_o;

  // shadow key table and scale
  logic [nmkt_pkg::IdWidth-1:0]  owner_of_key [nmkt_pkg::NumKeys];
  bit                            key_held [nmkt_pkg::NumKeys];
  logic [nmkt_pkg::CfgWidth-1:0] vel_scale;
  midi_note_t                    midi_notes_due [$];
  dir_row_t                      dir_rows [$];

  int mismatches    = 0;
  int events_sent   = 0;
  int note_ons      = 0;
  int drops         = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int hold_count    = 0;
  int cycles        = 0;
  bit calm          = 1'b0;
  bit pressure_go   = 1'b0;

  always #2 clk_i = ~clk_i;

  note_event_to_midi_key_tracker u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .gate_i          (gate_i),
    .note_id_i       (note_id_i),
    .has_frequency_i (has_frequency_i),
    .frequency_i     (frequency_i),
    .velocity_i      (velocity_i),
    .frame_time_i    (frame_time_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_note_on_o    (is_note_on_o),
    .key_o           (key_o),
    .midi_velocity_o (midi_velocity_o),
    .event_time_o    (event_time_o)
  );

  // exact key: count the boundaries f exceeds, compared on f^24 to stay integer
  function automatic logic [nmkt_pkg::KeyWidth-1:0] nearest_key(
    input logic [nmkt_pkg::FreqWidth-1:0] f
  );
    logic [1023:0] f_pow;
    logic [1023:0] ref_pow;
    int            k;
    f_pow   = 1;
    ref_pow = 1;
    for (int i = 0; i < 24; i++) begin
      f_pow   = f_pow * f;
      ref_pow = ref_pow * A440Q12;
    end
    f_pow = f_pow << 137;
    k     = 0;
    while (k < nmkt_pkg::NumKeys - 1 && f_pow > ref_pow) begin
      k++;
      ref_pow = ref_pow << 2;
    end
    return nmkt_pkg::KeyWidth'(k);
  endfunction

  function automatic logic [nmkt_pkg::MidiVelWidth-1:0] scaled_velocity(
    input logic signed [nmkt_pkg::VelInWidth-1:0] v
  );
    int prod;
    prod = int'(v) * int'(vel_scale);
    if (prod <= 0) return '0;
    if (prod / 4096 > 127) return nmkt_pkg::MidiVelMax;
    return nmkt_pkg::MidiVelWidth'(prod / 4096);
  endfunction

  // updates the shadow table, returns 1 when the event yields a midi message
  function automatic bit apply_note_event(input note_event_t ev, output midi_note_t res);
    logic [nmkt_pkg::KeyWidth-1:0] k;
    logic [nmkt_pkg::IdWidth-1:0]  id;
    id        = ev.id[nmkt_pkg::IdWidth-1:0];
    res.is_on = 1'b0;
    res.key   = '0;
    res.vel   = '0;
    res.etime = ev.ftime;
    if (ev.gate == GateOn) begin
      if (!ev.has_freq) return 1'b0;
      k = nearest_key(ev.freq);
      if (key_held[k]) return 1'b0;
      key_held[k]     = 1'b1;
      owner_of_key[k] = id;
      res.is_on       = 1'b1;
      res.key         = k;
      res.vel         = scaled_velocity(ev.vel);
      return 1'b1;
    end
    for (int i = 0; i < nmkt_pkg::NumKeys; i++) begin
      if (key_held[i] && owner_of_key[i] == id) begin
        key_held[i] = 1'b0;
        res.key     = nmkt_pkg::KeyWidth'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [nmkt_pkg::FreqWidth-1:0] key_freq_q12(input real semis);
    return nmkt_pkg::FreqWidth'($rtoi(1802240.0 * (2.0 ** ((semis - 69.0) / 12.0))));
  endfunction

  function automatic logic signed [nmkt_pkg::NoteIdWidth-1:0] held_id(output bit found);
    int keys [$];
    for (int i = 0; i < nmkt_pkg::NumKeys; i++)
      if (key_held[i]) keys.push_back(i);
    found = keys.size() != 0;
    if (!found) return $urandom;
    return owner_of_key[keys[$urandom_range(keys.size() - 1)]];
  endfunction

  // mostly well-formed on/off pairs, the rest unknown ids and odd frequencies
  function automatic note_event_t random_event();
    note_event_t                             ev;
    bit                                      found;
    int                                      pick;
    logic signed [nmkt_pkg::NoteIdWidth-1:0] busy_id;
    ev.gate     = ($urandom_range(99) < 50);
    ev.id       = $urandom;
    ev.has_freq = ($urandom_range(99) < 90);
    ev.freq     = $urandom;
    ev.vel      = nmkt_pkg::VelInWidth'($urandom);
    ev.ftime    = $urandom;
    busy_id     = held_id(found);
    if (ev.gate == GateOff) begin
      if (found && $urandom_range(99) < 75) ev.id = busy_id;
      return ev;
    end
    pick = $urandom_range(99);
    if (found && pick < 10) ev.id = busy_id;
    else if (pick < 15) ev.id = $urandom_range(3);
    pick = $urandom_range(99);
    if (pick < 55)
      ev.freq = key_freq_q12(real'($urandom_range(127))) + $urandom_range(200) - 100;
    else if (pick < 75)
      ev.freq = key_freq_q12(real'($urandom_range(126)) + 0.5) + $urandom_range(4) - 2;
    else if (pick < 85) ev.freq = $urandom_range(40000);
    else if (pick < 90) ev.freq = '1;
    if ($urandom_range(99) < 50) ev.vel = nmkt_pkg::VelInWidth'($urandom_range(5000));
    return ev;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  function automatic void add_row(input row_check_e chk, input bit gate,
                                  input logic signed [nmkt_pkg::NoteIdWidth-1:0] id,
                                  input bit hf,
                                  input logic [nmkt_pkg::FreqWidth-1:0] f,
                                  input logic signed [nmkt_pkg::VelInWidth-1:0] v,
                                  input logic [nmkt_pkg::TimeWidth-1:0] t,
                                  input int k = 0, input int mv = 0);
    dir_row_t r;
    r.check       = chk;
    r.ev.gate     = gate;
    r.ev.id       = id;
    r.ev.has_freq = hf;
    r.ev.freq     = f;
    r.ev.vel      = v;
    r.ev.ftime    = t;
    r.res.is_on   = gate;
    r.res.key     = nmkt_pkg::KeyWidth'(k);
    r.res.vel     = nmkt_pkg::MidiVelWidth'(mv);
    r.res.etime   = t;
    dir_rows.push_back(r);
  endfunction

  task automatic offer_event(input note_event_t ev);
    if (!calm) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    gate_i          <= ev.gate;
    note_id_i       <= ev.id;
    has_frequency_i <= ev.has_freq;
    frequency_i     <= ev.freq;
    velocity_i      <= ev.vel;
    frame_time_i    <= ev.ftime;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    events_sent++;
    if (ev.gate == GateOn) note_ons++;
  endtask

  task automatic send_event(input note_event_t ev, output bit got, output midi_note_t res);
    offer_event(ev);
    got = apply_note_event(ev, res);
    if (!got) drops++;
  endtask

  // dropped note-offs may still be scanning after the last result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (midi_notes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [nmkt_pkg::CfgWidth-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    vel_scale  = v;
    settings_used++;
  endtask

  task automatic check_midi_note();
    midi_note_t due;
    results_seen++;
    if (midi_notes_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected result on=%0b key=%0d vel=%0d time=%0h",
                              is_note_on_o, key_o, midi_velocity_o, event_time_o));
      return;
    end
    due = midi_notes_due.pop_front();
    if (is_note_on_o !== due.is_on)
      flag_mismatch($sformatf("result %0d is_note_on %0b, want %0b", results_seen,
                              is_note_on_o, due.is_on));
    if (key_o !== due.key)
      flag_mismatch($sformatf("result %0d key %0d, want %0d", results_seen, key_o, due.key));
    if (midi_velocity_o !== due.vel)
      flag_mismatch($sformatf("result %0d midi_velocity %0d, want %0d", results_seen,
                              midi_velocity_o, due.vel));
    if (event_time_o !== due.etime)
      flag_mismatch($sformatf("result %0d event_time %0h, want %0h", results_seen,
                              event_time_o, due.etime));
  endtask

  // output side: check each transaction, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) check_midi_note();
    if (pressure_go && hold_count < HoldCycles) begin
      out_stall_i <= 1'b1;
      hold_count++;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  initial begin
    while (cycles < LimitCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("note_event_to_midi_key_tracker regression: fail");
    $finish;
  end

  initial begin
    note_event_t ev;
    midi_note_t  res;
    bit          got;
    int          phase_scale [NumPhases];
    phase_scale = '{255, 0, 1, 128, 200, 64};
    phase_scale[5] = $urandom_range(254, 2);
    for (int i = 0; i < nmkt_pkg::NumKeys; i++) begin
      key_held[i]     = 1'b0;
      owner_of_key[i] = '0;
    end
    vel_scale = nmkt_pkg::BaseVelReset;

    // 440 Hz is key 69, velocity 1.0 at scale 127 is 127
    add_row(CHK_NOTE,  GateOn,  1,  1, A440Q12,       16'sd4096,  32'd10, 69, 127);
    add_row(CHK_NONE,  GateOn,  2,  1, A440Q12,       16'sd4096,  32'd11);
    add_row(CHK_NONE,  GateOn,  3,  0, 32'd3604480,   16'sd4096,  32'd12);
    add_row(CHK_NOTE,  GateOn,  0,  1, 32'd0,         16'sd32767, 32'd0, 0, 127);
    add_row(CHK_NOTE,  GateOn,  -1, 1, 32'hFFFF_FFFF, 16'sh8000,  32'hFFFF_FFFF, 127, 0);
    add_row(CHK_NONE,  GateOff, 5,  1, 32'd0,         16'sd0,     32'd13);
    add_row(CHK_NOTE,  GateOff, 0,  0, 32'hFFFF_FFFF, 16'sd32767, 32'd7, 0, 0);
    add_row(CHK_NONE,  GateOff, 0,  0, 32'd0,         16'sd0,     32'd8);
    add_row(CHK_NOTE,  GateOff, 1,  1, A440Q12,       16'sd4096,  32'd9, 69, 0);
    add_row(CHK_NOTE,  GateOff, -1, 1, 32'd0,         -16'sd1,    32'h8000_0000, 127, 0);
    add_row(CHK_NOTE,  GateOn,  7,  1, A440Q12,       16'sd0,     32'd20, 69, 0);
    add_row(CHK_MODEL, GateOn,  8,  1, 32'd3604480,   16'sd1,     32'd21);
    add_row(CHK_MODEL, GateOn,  9,  1, 32'd1071618,   16'sd33,    32'd22);
    add_row(CHK_MODEL, GateOn,  9,  1, 32'd601426,    -16'sd1,    32'd23);
    add_row(CHK_MODEL, GateOn,  10, 1, 32'd1,         16'sd4128,  32'd24);
    // same id on two keys: the lower key goes first
    add_row(CHK_MODEL, GateOff, 9,  0, 32'd0,         16'sd0,     32'd25);
    add_row(CHK_MODEL, GateOff, 9,  0, 32'd0,         16'sd0,     32'd26);
    // straddle the boundary above key 69
    add_row(CHK_MODEL, GateOn,  12, 1, 32'd1855049,   16'sd2048,  32'd27);
    add_row(CHK_MODEL, GateOn,  13, 1, 32'd1855050,   16'sd2048,  32'd28);
    add_row(CHK_MODEL, GateOn,  14, 1, 32'd6061978,   16'sd4161,  32'd29);
    add_row(CHK_MODEL, GateOff, 7,  0, 32'd0,         16'sd0,     32'd30);
    add_row(CHK_MODEL, GateOff, 12, 0, 32'd0,         16'sd0,     32'd31);
    add_row(CHK_MODEL, GateOff, 13, 0, 32'd0,         16'sd0,     32'd32);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_event(dir_rows[i].ev, got, res);
      case (dir_rows[i].check)
        CHK_MODEL: begin
          if (got) midi_notes_due.push_back(res);
        end
        CHK_NOTE: begin
          midi_notes_due.push_back(dir_rows[i].res);
        end
        default: begin
        end
      endcase
    end
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      write_scale(nmkt_pkg::CfgWidth'(phase_scale[p]));
      calm        <= (p == 1);
      pressure_go <= (p == 3);
      repeat (PhaseItems) begin
        ev = random_event();
        send_event(ev, got, res);
        if (got) midi_notes_due.push_back(res);
      end
      settle();
    end

    $display("covered %0d note events (%0d note-on, %0d dropped) over %0d velocity scales",
             events_sent, note_ons, drops, settings_used + 1);
    $display("checked %0d midi transactions, %0d mismatches, one %0d-cycle output hold-off",
             results_seen, mismatches, HoldCycles);
    if (mismatches == 0) begin
      $display("note_event_to_midi_key_tracker regression: pass");
    end else begin
      $display("note_event_to_midi_key_tracker regression: fail");
    end
    $finish;
  end

endmodule
